// ----- sv/smc_pkg.sv -----
// ============================================================================
// smc_pkg
// Shared types and constants for the selectable message checksum.
// ============================================================================
package smc_pkg;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_SUM    = 2'd1,
        MODE_CRC    = 2'd2,
        MODE_SHA    = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RUN,
        ST_PAD,
        ST_PAD_RUN,
        ST_LEN,
        ST_LEN_RUN,
        ST_RESULT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic       take_byte;   // absorb data_byte into sum, crc and byte count
        logic       buf_write;   // write buf_wdata at buf_idx
        logic [5:0] buf_idx;
        logic [7:0] buf_wdata;
        logic       round_start; // load round words from hash
        logic       round_step;  // one SHA round
        logic [5:0] round_idx;
        logic       hash_add;    // fold round words into hash
        logic       load_result;
        logic       clear;
    } smc_cmd_t;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam logic [5:0]  LEN_START = 6'd56;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    localparam logic [31:0] HASH_INIT [8] = '{
        32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
        32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19
    };

endpackage

// ----- sv/selectable_message_checksum.sv -----
// ============================================================================
// selectable_message_checksum
// Message checksum over bytes: none, byte sum, CRC-32 or SHA-256 word H0.
// ============================================================================
//  channel | signals                              | accepted when
//  in      | in_valid in_stall data_byte has_byte is_last | valid && !stall
//  out     | out_valid out_stall checksum         | valid && !stall
//  cfg     | psel penable pwrite paddr pwdata prdata pready | write access
//
//  A byte is taken in ST_IDLE; a byte that fills a 64-byte block then runs the
//  SHA-256 rounds, one round per cycle. A last word then goes to ST_RESULT,
//  in SHA mode via padding bytes one per cycle and one or two 64-round blocks.
//  Reset spares buffers; a new word is taken only once the result has left.
module selectable_message_checksum (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] checksum,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import smc_pkg::*;

    logic [1:0]  mode_reg;
    smc_cmd_t    cmd;
    logic [5:0]  fill;
    logic [63:0] bit_len;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {30'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_NONE;
        else if (psel && penable && pwrite && paddr == 2'd0)
            mode_reg <= pwdata[1:0];
    end

    smc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .has_byte(has_byte), .is_last(is_last),
        .mode(mode_reg), .fill(fill), .bit_len(bit_len), .cmd(cmd),
        .out_valid(out_valid), .out_stall(out_stall)
    );

    smc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .mode(mode_reg),
        .data_byte(data_byte), .fill(fill), .bit_len(bit_len), .checksum(checksum)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken with result pending");
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> out_valid) else $error("result lost");
    a_no_take_in_round: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round_step |-> !cmd.take_byte) else $error("byte during rounds");

endmodule

// ----- sv/smc_ctrl.sv -----
// ============================================================================
// smc_ctrl
// Sequencer: byte intake, SHA-256 block rounds, padding and result handoff.
// ============================================================================
module smc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                has_byte,
    input  logic                is_last,
    input  logic [1:0]          mode,
    input  logic [5:0]          fill,      // bytes in current block
    input  logic [63:0]         bit_len,
    output smc_pkg::smc_cmd_t   cmd,
    output logic                out_valid,
    input  logic                out_stall
);
    import smc_pkg::*;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       last_reg, last_next;
    logic       ov_reg, ov_next;
    logic       acc;
    logic       block_full;
    logic       is_sha;

    assign is_sha     = (mode_t'(mode) == MODE_SHA);
    assign in_stall   = (state_reg != ST_IDLE) || ov_reg;
    assign acc        = in_valid && !in_stall;
    assign block_full = has_byte && (fill == 6'd63);
    assign out_valid  = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    last_next = is_last;
                    cnt_next  = 6'd0;
                    if (block_full)
                        state_next = ST_RUN;
                    else if (is_last)
                        state_next = is_sha ? ST_PAD : ST_RESULT;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = last_reg ? (is_sha ? ST_PAD : ST_RESULT) : ST_IDLE;
            end
            ST_PAD:
            begin
                cnt_next = 6'd0;
                if (fill == 6'd63)
                    state_next = ST_PAD_RUN;
                else if (fill >= LEN_START)
                    state_next = ST_PAD;
                else
                    state_next = ST_LEN;
            end
            ST_PAD_RUN:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = ST_LEN;
            end
            ST_LEN:
            begin
                cnt_next = 6'd0;
                if (fill == 6'd63)
                    state_next = ST_LEN_RUN;
            end
            ST_LEN_RUN:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        if (state_reg == ST_RESULT)
            ov_next = 1'b1;
    end

    // buffer write mux: pad bytes zero except the mark, length bytes big-endian
    logic [7:0] len_byte;
    always_comb
    begin
        len_byte = bit_len[{~fill[2:0], 3'b000} +: 8];
    end

    always_comb
    begin
        cmd             = '0;
        cmd.buf_idx     = fill;
        cmd.round_idx   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take_byte = acc && has_byte;
                cmd.buf_write = acc && has_byte;
                cmd.buf_wdata = data_byte;
                cmd.round_start = acc && block_full;
            end
            ST_RUN, ST_PAD_RUN, ST_LEN_RUN:
            begin
                cmd.round_step = 1'b1;
                cmd.hash_add   = (cnt_reg == 6'd63);
            end
            ST_PAD:
            begin
                cmd.buf_write   = 1'b1;
                cmd.buf_wdata   = last_reg ? PAD_MARK : 8'd0;
                cmd.round_start = (fill == 6'd63);
            end
            ST_LEN:
            begin
                cmd.buf_write   = 1'b1;
                cmd.buf_wdata   = (fill >= LEN_START) ? len_byte : 8'd0;
                cmd.round_start = (fill == 6'd63);
            end
            ST_RESULT:
            begin
                cmd.load_result = 1'b1;
                cmd.clear       = 1'b1;
            end
            default:
            begin
                cmd.buf_wdata = 8'd0;
            end
        endcase
    end

    // last_reg doubles as "mark not yet written" during padding
    logic last_pad;
    assign last_pad = (state_reg == ST_PAD) ? 1'b0 : last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 6'd0;
            last_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_pad;
            ov_reg    <= ov_next;
        end
    end

endmodule

// ----- sv/smc_datapath.sv -----
// ============================================================================
// smc_datapath
// Byte sum, bitwise CRC-32, block buffer, SHA-256 round unit and hash state.
// ============================================================================
module smc_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  smc_pkg::smc_cmd_t   cmd,
    input  logic [1:0]          mode,
    input  logic [7:0]          data_byte,
    output logic [5:0]          fill,
    output logic [63:0]         bit_len,
    output logic [31:0]         checksum
);
    import smc_pkg::*;

    logic [31:0] sum_reg;
    logic [31:0] crc_reg, crc_next;
    logic [60:0] count_reg;
    logic [5:0]  pfill_reg;           // padding write position
    logic [31:0] hash_reg [8];
    logic [31:0] rw_reg [8];
    logic [31:0] win_reg [16];
    logic [31:0] buf_reg [16];        // block as big-endian words
    logic [31:0] res_reg;
    logic        pad_mode_reg;

    assign bit_len  = {count_reg, 3'b000};
    assign fill     = pad_mode_reg ? pfill_reg : count_reg[5:0];
    assign checksum = res_reg;

    always_comb
    begin
        crc_next = crc_reg ^ {24'd0, data_byte};
        for (int k = 0; k < 8; k++)
            crc_next = crc_next[0] ? ((crc_next >> 1) ^ CRC_POLY) : (crc_next >> 1);
    end

    // message schedule word for this round
    logic [31:0] w, w2, w15, s0, s1, t1, t2, a, e, wb;
    logic [5:0]  ri;
    always_comb
    begin
        ri  = cmd.round_idx;
        wb  = buf_reg[ri[3:0]];
        w2  = win_reg[4'(ri - 6'd2)];
        w15 = win_reg[4'(ri - 6'd15)];
        s0  = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
        s1  = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
        w   = (ri < 6'd16) ? wb
              : s1 + win_reg[4'(ri - 6'd7)] + s0 + win_reg[ri[3:0]];
        a   = rw_reg[0];
        e   = rw_reg[4];
        t1  = rw_reg[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
              + ((e & rw_reg[5]) ^ (~e & rw_reg[6])) + ROUND_K[ri] + w;
        t2  = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
              + ((a & rw_reg[1]) ^ (a & rw_reg[2]) ^ (rw_reg[1] & rw_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.buf_write)
            buf_reg[cmd.buf_idx[5:2]][{~cmd.buf_idx[1:0], 3'b000} +: 8] <= cmd.buf_wdata;
        if (cmd.round_step)
            win_reg[ri[3:0]] <= w;
        if (cmd.round_start)
            rw_reg <= hash_reg;
        else if (cmd.round_step)
        begin
            rw_reg[7] <= rw_reg[6];
            rw_reg[6] <= rw_reg[5];
            rw_reg[5] <= rw_reg[4];
            rw_reg[4] <= rw_reg[3] + t1;
            rw_reg[3] <= rw_reg[2];
            rw_reg[2] <= rw_reg[1];
            rw_reg[1] <= rw_reg[0];
            rw_reg[0] <= t1 + t2;
        end
        if (cmd.load_result)
        begin
            case (mode_t'(mode))
                MODE_SUM: res_reg <= sum_reg;
                MODE_CRC: res_reg <= crc_reg ^ ALL_ONES;
                MODE_SHA: res_reg <= hash_reg[0];
                default:  res_reg <= 32'd0;
            endcase
        end
    end

    // hash_add fires on the last round, whose update is not yet in rw_reg
    logic [31:0] rw_last [8];
    always_comb
    begin
        rw_last[0] = t1 + t2;
        rw_last[1] = rw_reg[0];
        rw_last[2] = rw_reg[1];
        rw_last[3] = rw_reg[2];
        rw_last[4] = rw_reg[3] + t1;
        rw_last[5] = rw_reg[4];
        rw_last[6] = rw_reg[5];
        rw_last[7] = rw_reg[6];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= 32'd0;
            crc_reg      <= ALL_ONES;
            count_reg    <= '0;
            pfill_reg    <= 6'd0;
            pad_mode_reg <= 1'b0;
            hash_reg     <= HASH_INIT;
        end
        else if (cmd.clear)
        begin
            sum_reg      <= 32'd0;
            crc_reg      <= ALL_ONES;
            count_reg    <= '0;
            pfill_reg    <= 6'd0;
            pad_mode_reg <= 1'b0;
            hash_reg     <= HASH_INIT;
        end
        else
        begin
            if (cmd.take_byte)
            begin
                sum_reg   <= sum_reg + {24'd0, data_byte};
                crc_reg   <= crc_next;
                count_reg <= count_reg + 61'd1;
            end
            else if (cmd.buf_write)
            begin
                pad_mode_reg <= 1'b1;
                pfill_reg    <= fill + 6'd1;
            end
            if (cmd.hash_add)
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= hash_reg[i] + rw_last[i];
        end
    end

endmodule
